/* src/srfc_pkg.sv */
// Shared types and constants for the sensor response frame checker.
package srfc_pkg;

	localparam int FrameBytes   = 30;
	localparam int CrcBytes     = 28;
	localparam int CaptureFirst = 8;
	localparam int CaptureBytes = 20;
	localparam int PosWidth     = 5;

	localparam logic [15:0] CRC_INIT      = 16'hFFFF;
	localparam logic [15:0] CRC_POLY_REFL = 16'hA001;
	localparam logic [7:0]  HEADER_FIRST  = 8'h52;
	localparam logic [7:0]  HEADER_SECOND = 8'h42;
	localparam logic [15:0] EXPECTED_LEN  = 16'd26;

	localparam logic [PosWidth-1:0] POS_HEADER_0 = PosWidth'(0);
	localparam logic [PosWidth-1:0] POS_HEADER_1 = PosWidth'(1);
	localparam logic [PosWidth-1:0] POS_LEN_LO   = PosWidth'(2);
	localparam logic [PosWidth-1:0] POS_LEN_HI   = PosWidth'(3);
	localparam logic [PosWidth-1:0] POS_CAP_LO   = PosWidth'(CaptureFirst);
	localparam logic [PosWidth-1:0] POS_CRC_LO   = PosWidth'(CrcBytes);
	localparam logic [PosWidth-1:0] POS_LAST     = PosWidth'(FrameBytes - 1);

	localparam logic [1:0] STATUS_OK         = 2'd0;
	localparam logic [1:0] STATUS_BAD_HEADER = 2'd1;
	localparam logic [1:0] STATUS_BAD_LENGTH = 2'd2;
	localparam logic [1:0] STATUS_BAD_CRC    = 2'd3;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       restart;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [15:0] temperature_raw;
		logic [15:0] humidity_raw;
		logic [15:0] light_raw;
		logic [31:0] pressure_raw;
		logic [15:0] noise_raw;
		logic [15:0] tvoc_raw;
		logic [15:0] co2_raw;
		logic [15:0] discomfort_raw;
		logic [15:0] heat_stroke_raw;
	} out_item_t;

endpackage

/* src/sensor_response_frame_checker_top.sv */
// Frame checker: byte intake, CRC-16 update, field capture and result register.
//
// channel | dir | handshake          | payload
// in      | in  | in_valid/in_ready  | in_item  (data_byte, restart)
// out     | out | out_valid/out_ready| out_item (status, nine raw fields)
//
// One byte per cycle while no stalled result holds intake: a byte sits in the
// input register, where the bytewise CRC update (eight shift steps) and the checks
// run, then the frame's last byte (byte 29) loads the result register and sets out_valid.
// Reset clears position, flags, CRC and valid bits; capture registers need none.
// A result stalled at the output holds intake only when another result is due.
module sensor_response_frame_checker_top (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  srfc_pkg::in_item_t  in_item,
	output logic                out_valid,
	input  logic                out_ready,
	output srfc_pkg::out_item_t out_item
);
	import srfc_pkg::*;

	function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
		logic [15:0] c;
		c = crc_in ^ {8'h00, b};
		for (int i = 0; i < 8; i++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY_REFL;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

	logic                valid_s1;
	in_item_t            item_s1;
	logic [PosWidth-1:0] pos_q;
	logic [15:0]         crc_q;
	logic                header_bad_q;
	logic                length_bad_q;
	logic [7:0]          len_lo_q;
	logic [7:0]          crc_lo_q;
	logic [7:0]          cap_q [CaptureBytes];
	logic                out_valid_q;
	out_item_t           out_item_q;

	logic [PosWidth-1:0] pos;
	logic [PosWidth-1:0] cap_idx;
	logic [15:0]         crc_base;
	logic                hb_base;
	logic                lb_base;
	logic                hb_next;
	logic                lb_next;
	logic                last;
	logic                stall_s1;
	logic                advance;
	logic [1:0]          status;

	// restart drops the partial frame before this byte is taken
	always_comb begin
		pos      = item_s1.restart ? POS_HEADER_0 : pos_q;
		crc_base = item_s1.restart ? CRC_INIT : crc_q;
		hb_base  = item_s1.restart ? 1'b0 : header_bad_q;
		lb_base  = item_s1.restart ? 1'b0 : length_bad_q;
		cap_idx  = pos - POS_CAP_LO;
		last     = (pos == POS_LAST);
		hb_next  = hb_base;
		lb_next  = lb_base;
		if (pos == POS_HEADER_0 && item_s1.data_byte != HEADER_FIRST) begin
			hb_next = 1'b1;
		end
		if (pos == POS_HEADER_1 && item_s1.data_byte != HEADER_SECOND) begin
			hb_next = 1'b1;
		end
		if (pos == POS_LEN_HI && {item_s1.data_byte, len_lo_q} != EXPECTED_LEN) begin
			lb_next = 1'b1;
		end
		priority if (hb_base) begin
			status = STATUS_BAD_HEADER;
		end else if (lb_base) begin
			status = STATUS_BAD_LENGTH;
		end else if ({item_s1.data_byte, crc_lo_q} != crc_base) begin
			status = STATUS_BAD_CRC;
		end else begin
			status = STATUS_OK;
		end
	end

	assign stall_s1 = valid_s1 && last && out_valid_q && !out_ready;
	assign advance  = valid_s1 && !stall_s1;
	assign in_ready = !stall_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_item;
		end
	end

	// frame state advances once per byte leaving the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q        <= POS_HEADER_0;
			crc_q        <= CRC_INIT;
			header_bad_q <= 1'b0;
			length_bad_q <= 1'b0;
		end else if (advance) begin
			if (last) begin
				pos_q        <= POS_HEADER_0;
				crc_q        <= CRC_INIT;
				header_bad_q <= 1'b0;
				length_bad_q <= 1'b0;
			end else begin
				pos_q        <= pos + PosWidth'(1);
				crc_q        <= (pos < POS_CRC_LO) ? crc_byte(crc_base, item_s1.data_byte)
				                                   : crc_base;
				header_bad_q <= hb_next;
				length_bad_q <= lb_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			if (pos == POS_LEN_LO) begin
				len_lo_q <= item_s1.data_byte;
			end
			if (pos == POS_CRC_LO) begin
				crc_lo_q <= item_s1.data_byte;
			end
			if (pos >= POS_CAP_LO && pos < POS_CRC_LO) begin
				cap_q[cap_idx] <= item_s1.data_byte;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && last) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && last) begin
			out_item_q.status          <= status;
			out_item_q.temperature_raw <= {cap_q[1], cap_q[0]};
			out_item_q.humidity_raw    <= {cap_q[3], cap_q[2]};
			out_item_q.light_raw       <= {cap_q[5], cap_q[4]};
			out_item_q.pressure_raw    <= {cap_q[9], cap_q[8], cap_q[7], cap_q[6]};
			out_item_q.noise_raw       <= {cap_q[11], cap_q[10]};
			out_item_q.tvoc_raw        <= {cap_q[13], cap_q[12]};
			out_item_q.co2_raw         <= {cap_q[15], cap_q[14]};
			out_item_q.discomfort_raw  <= {cap_q[17], cap_q[16]};
			out_item_q.heat_stroke_raw <= {cap_q[19], cap_q[18]};
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

endmodule

/* src/srfc_checker.sv */
// Port-level assertions for the frame checker, bound to the top level.
module srfc_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_ready,
	input srfc_pkg::in_item_t  in_item,
	input logic                out_valid,
	input logic                out_ready,
	input srfc_pkg::out_item_t out_item
);
	import srfc_pkg::*;

	logic [PosWidth-1:0] pos_q;
	logic [PosWidth-1:0] pos;
	logic [1:0]          pend_q;
	logic                in_xfer;
	logic                out_xfer;
	logic                in_last;

	assign in_xfer  = in_valid && in_ready;
	assign out_xfer = out_valid && out_ready;
	assign pos      = in_item.restart ? POS_HEADER_0 : pos_q;
	assign in_last  = in_xfer && (pos == POS_LAST);

	// track frame position and results owed from the port side
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= POS_HEADER_0;
			pend_q <= 2'd0;
		end else begin
			if (in_xfer) begin
				pos_q <= in_last ? POS_HEADER_0 : pos + PosWidth'(1);
			end
			pend_q <= pend_q + {1'b0, in_last} - {1'b0, out_xfer};
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_item))
		else $error("result changed or dropped while stalled");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pend_q != 2'd0)
		else $error("result shown without a completed frame");

	a_pend_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q != 2'd3)
		else $error("more frames completed than the block can hold");

	a_ready_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("intake held without a stalled result");

endmodule

bind sensor_response_frame_checker_top srfc_checker u_srfc_checker (.*);
